// File: rtl/cts_pkg.sv
// types, constants and the keyword table of the c token scanner
// no dependencies
`default_nettype none

package cts_pkg;

    localparam int MAX_WORD_DEF = 32;
    localparam int Q_DEPTH      = 4;
    localparam int Q_AW         = $clog2(Q_DEPTH);

    localparam logic [23:0] LINE_MAX = 24'hFFFFFF;
    localparam logic [6:0]  KIND_END = 7'd0;
    localparam logic [6:0]  KIND_INT = 7'd47;
    localparam logic [6:0]  KIND_KW0 = 7'd48;

    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_BADCHAR = 3'd1;
    localparam logic [2:0] ERR_DOTS    = 3'd2;
    localparam logic [2:0] ERR_WORD    = 3'd3;
    localparam logic [2:0] ERR_LONG    = 3'd4;

    typedef enum logic [18:0] {
        M_START  = 19'h00001,
        M_PLUS   = 19'h00002,
        M_MINUS  = 19'h00004,
        M_STAR   = 19'h00008,
        M_SLASH  = 19'h00010,
        M_GT     = 19'h00020,
        M_GTGT   = 19'h00040,
        M_LT     = 19'h00080,
        M_LTLT   = 19'h00100,
        M_DOT    = 19'h00200,
        M_DOTDOT = 19'h00400,
        M_PCT    = 19'h00800,
        M_AMP    = 19'h01000,
        M_CARET  = 19'h02000,
        M_PIPE   = 19'h04000,
        M_BANG   = 19'h08000,
        M_EQ     = 19'h10000,
        M_NUM    = 19'h20000,
        M_WORD   = 19'h40000
    } t_mode;

    typedef struct packed {
        logic [6:0]  kind;
        logic [31:0] value;
        logic [2:0]  err;
        logic [23:0] line;
        logic        last;
    } t_result;

    // last letter in the low byte, zero padded above
    localparam logic [63:0] KW_TXT [32] = '{
        64'("auto"), 64'("break"), 64'("case"), 64'("char"), 64'("const"),
        64'("continue"), 64'("default"), 64'("do"), 64'("double"), 64'("else"),
        64'("enum"), 64'("extern"), 64'("float"), 64'("for"), 64'("goto"),
        64'("if"), 64'("int"), 64'("long"), 64'("register"), 64'("return"),
        64'("short"), 64'("signed"), 64'("sizeof"), 64'("static"),
        64'("struct"), 64'("switch"), 64'("typedef"), 64'("union"),
        64'("unsigned"), 64'("void"), 64'("volatile"), 64'("while")
    };
    localparam logic [3:0] KW_LEN [32] = '{
        4'd4, 4'd5, 4'd4, 4'd4, 4'd5, 4'd8, 4'd7, 4'd2, 4'd6, 4'd4, 4'd4, 4'd6,
        4'd5, 4'd3, 4'd4, 4'd2, 4'd3, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd6, 4'd6,
        4'd6, 4'd6, 4'd7, 4'd5, 4'd8, 4'd4, 4'd8, 4'd5
    };

    function automatic logic [5:0] kw_find(input logic [63:0] w, input logic [3:0] len);
        logic [5:0] r;
        r = '0;
        for (int k = 0; k < 32; k++) begin
            if (KW_TXT[k] == w && KW_LEN[k] == len) begin
                r = {1'b1, 5'(k)};
            end
        end
        return r;
    endfunction

    function automatic logic [6:0] flush_kind(input t_mode m);
        logic [6:0] k;
        case (m)
            M_PLUS:  k = 7'd3;
            M_MINUS: k = 7'd7;
            M_STAR:  k = 7'd9;
            M_SLASH: k = 7'd11;
            M_GT:    k = 7'd15;
            M_GTGT:  k = 7'd13;
            M_LT:    k = 7'd19;
            M_LTLT:  k = 7'd17;
            M_DOT:   k = 7'd21;
            M_PCT:   k = 7'd23;
            M_AMP:   k = 7'd26;
            M_CARET: k = 7'd28;
            M_PIPE:  k = 7'd31;
            M_BANG:  k = 7'd36;
            M_EQ:    k = 7'd39;
            default: k = KIND_END;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

// File: rtl/cts_core.sv
// scanner state and per-byte token logic, up to two results per byte
// depends on cts_pkg
`default_nettype none

module cts_core #(
    parameter int MaxWord = cts_pkg::MAX_WORD_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_go,
    input  wire logic [7:0]       i_byte,
    input  wire logic             i_end,
    output logic [1:0]            o_cnt,
    output cts_pkg::t_result      o_res [2]
);
    localparam int LW = $clog2(MaxWord + 1);

    cts_pkg::t_mode r_mode, n_mode;
    logic [31:0] r_acc, n_acc;
    logic [63:0] r_word, n_word;
    logic [LW-1:0] r_len, n_len;
    logic [23:0] r_line, n_line;
    logic r_halt, n_halt;

    logic [23:0] line;
    logic [5:0] kw;
    logic ext_ok, want_start, f_emit, is_digit, is_lower;
    logic [6:0] ext_kind, f_kind, s_kind;
    logic [2:0] f_err;
    logic s_bad;
    cts_pkg::t_mode ext_mode, s_mode;
    logic [1:0] cnt;
    cts_pkg::t_result res [2];

    function automatic cts_pkg::t_result mk(input logic [6:0] k, input logic [31:0] v,
                                            input logic [2:0] e, input logic [23:0] l);
        cts_pkg::t_result r;
        r.kind = k; r.value = v; r.err = e; r.line = l; r.last = 1'b0;
        return r;
    endfunction

    always_comb begin
        is_digit = (i_byte inside {[8'h30:8'h39]});
        is_lower = (i_byte inside {[8'h61:8'h7A]});
        kw = cts_pkg::kw_find(r_word, r_len[3:0]);
        line = (!i_end && i_byte == 8'h0A && r_line != cts_pkg::LINE_MAX)
               ? r_line + 24'd1 : r_line;

        // extension of the pending token
        ext_ok = 1'b0; ext_kind = cts_pkg::KIND_END; ext_mode = cts_pkg::M_START;
        case (r_mode)
            cts_pkg::M_PLUS: begin
                if (i_byte == "=") begin ext_ok = 1'b1; ext_kind = 7'd1; end
                if (i_byte == "+") begin ext_ok = 1'b1; ext_kind = 7'd2; end
            end
            cts_pkg::M_MINUS: begin
                if (i_byte == "=") begin ext_ok = 1'b1; ext_kind = 7'd4; end
                if (i_byte == "-") begin ext_ok = 1'b1; ext_kind = 7'd5; end
                if (i_byte == ">") begin ext_ok = 1'b1; ext_kind = 7'd6; end
            end
            cts_pkg::M_STAR:  if (i_byte == "=") begin ext_ok = 1'b1; ext_kind = 7'd8; end
            cts_pkg::M_SLASH: if (i_byte == "=") begin ext_ok = 1'b1; ext_kind = 7'd10; end
            cts_pkg::M_GT: begin
                if (i_byte == ">") begin ext_ok = 1'b1; ext_mode = cts_pkg::M_GTGT; end
                if (i_byte == "=") begin ext_ok = 1'b1; ext_kind = 7'd14; end
            end
            cts_pkg::M_GTGT:  if (i_byte == "=") begin ext_ok = 1'b1; ext_kind = 7'd12; end
            cts_pkg::M_LT: begin
                if (i_byte == "<") begin ext_ok = 1'b1; ext_mode = cts_pkg::M_LTLT; end
                if (i_byte == "=") begin ext_ok = 1'b1; ext_kind = 7'd18; end
            end
            cts_pkg::M_LTLT:  if (i_byte == "=") begin ext_ok = 1'b1; ext_kind = 7'd16; end
            cts_pkg::M_DOT:
                if (i_byte == ".") begin ext_ok = 1'b1; ext_mode = cts_pkg::M_DOTDOT; end
            cts_pkg::M_DOTDOT: if (i_byte == ".") begin ext_ok = 1'b1; ext_kind = 7'd20; end
            cts_pkg::M_PCT:   if (i_byte == "=") begin ext_ok = 1'b1; ext_kind = 7'd22; end
            cts_pkg::M_AMP: begin
                if (i_byte == "=") begin ext_ok = 1'b1; ext_kind = 7'd24; end
                if (i_byte == "&") begin ext_ok = 1'b1; ext_kind = 7'd25; end
            end
            cts_pkg::M_CARET: if (i_byte == "=") begin ext_ok = 1'b1; ext_kind = 7'd27; end
            cts_pkg::M_PIPE: begin
                if (i_byte == "=") begin ext_ok = 1'b1; ext_kind = 7'd29; end
                if (i_byte == "|") begin ext_ok = 1'b1; ext_kind = 7'd30; end
            end
            cts_pkg::M_BANG:  if (i_byte == "=") begin ext_ok = 1'b1; ext_kind = 7'd35; end
            cts_pkg::M_EQ:    if (i_byte == "=") begin ext_ok = 1'b1; ext_kind = 7'd38; end
            cts_pkg::M_NUM:   ext_ok = is_digit;
            cts_pkg::M_WORD:  ext_ok = is_lower;
            default:          ext_ok = 1'b0;
        endcase

        // pending token ended by a byte that does not extend it
        f_emit = 1'b1; f_kind = cts_pkg::KIND_END; f_err = cts_pkg::ERR_NONE;
        case (r_mode)
            cts_pkg::M_START:  f_emit = 1'b0;
            cts_pkg::M_NUM:    f_kind = cts_pkg::KIND_INT;
            cts_pkg::M_DOTDOT: f_err = cts_pkg::ERR_DOTS;
            cts_pkg::M_WORD: begin
                if (kw[5] && r_len <= LW'(8)) f_kind = cts_pkg::KIND_KW0 + {2'b00, kw[4:0]};
                else f_err = cts_pkg::ERR_WORD;
            end
            default:           f_kind = cts_pkg::flush_kind(r_mode);
        endcase

        // first byte of a token
        s_kind = cts_pkg::KIND_END; s_bad = 1'b0; s_mode = cts_pkg::M_START;
        case (i_byte)
            " ", 8'h09, 8'h0A, 8'h0D: s_mode = cts_pkg::M_START;
            "+": s_mode = cts_pkg::M_PLUS;
            "-": s_mode = cts_pkg::M_MINUS;
            "*": s_mode = cts_pkg::M_STAR;
            "/": s_mode = cts_pkg::M_SLASH;
            ">": s_mode = cts_pkg::M_GT;
            "<": s_mode = cts_pkg::M_LT;
            ".": s_mode = cts_pkg::M_DOT;
            "%": s_mode = cts_pkg::M_PCT;
            "&": s_mode = cts_pkg::M_AMP;
            "^": s_mode = cts_pkg::M_CARET;
            "|": s_mode = cts_pkg::M_PIPE;
            "!": s_mode = cts_pkg::M_BANG;
            "=": s_mode = cts_pkg::M_EQ;
            "{": s_kind = 7'd32;
            "}": s_kind = 7'd33;
            ";": s_kind = 7'd34;
            "~": s_kind = 7'd37;
            ",": s_kind = 7'd40;
            ":": s_kind = 7'd41;
            "(": s_kind = 7'd42;
            ")": s_kind = 7'd43;
            "[": s_kind = 7'd44;
            "]": s_kind = 7'd45;
            "?": s_kind = 7'd46;
            default: begin
                if (is_digit) s_mode = cts_pkg::M_NUM;
                else if (is_lower) s_mode = cts_pkg::M_WORD;
                else s_bad = 1'b1;
            end
        endcase

        n_mode = r_mode; n_acc = r_acc; n_word = r_word; n_len = r_len;
        n_line = r_line; n_halt = r_halt;
        cnt = 2'd0; res[0] = '0; res[1] = '0;
        want_start = 1'b0;

        if (i_go && !r_halt) begin
            n_line = line;
            if (i_end) begin
                n_mode = cts_pkg::M_START;
                if (f_emit) begin
                    res[cnt[0]] = mk(f_kind, (r_mode == cts_pkg::M_NUM) ? r_acc : 32'd0,
                                     f_err, line);
                    cnt = cnt + 2'd1;
                end
                if (f_err != cts_pkg::ERR_NONE) begin
                    n_halt = 1'b1;
                end else begin
                    res[cnt[0]] = mk(cts_pkg::KIND_END, 32'd0, cts_pkg::ERR_NONE, line);
                    cnt = cnt + 2'd1;
                end
            end else if (r_mode == cts_pkg::M_START) begin
                want_start = 1'b1;
            end else if (ext_ok) begin
                if (r_mode == cts_pkg::M_WORD) begin
                    if (r_len >= LW'(MaxWord)) begin
                        res[0] = mk(cts_pkg::KIND_END, 32'd0, cts_pkg::ERR_LONG, line);
                        cnt = 2'd1;
                        n_halt = 1'b1;
                    end else begin
                        n_len = r_len + LW'(1);
                        // only words of up to eight letters can match
                        if (r_len < LW'(8)) n_word = {r_word[55:0], i_byte};
                    end
                end else if (r_mode == cts_pkg::M_NUM) begin
                    n_acc = {r_acc[28:0], 3'b000} + {r_acc[30:0], 1'b0}
                            + {28'd0, i_byte[3:0]};
                end else begin
                    n_mode = ext_mode;
                    if (ext_kind != cts_pkg::KIND_END) begin
                        res[0] = mk(ext_kind, 32'd0, cts_pkg::ERR_NONE, line);
                        cnt = 2'd1;
                    end
                end
            end else begin
                n_mode = cts_pkg::M_START;
                res[0] = mk(f_kind, (r_mode == cts_pkg::M_NUM) ? r_acc : 32'd0, f_err, line);
                cnt = 2'd1;
                if (f_err != cts_pkg::ERR_NONE) n_halt = 1'b1;
                else want_start = 1'b1;
            end

            if (want_start) begin
                if (s_bad) begin
                    res[cnt[0]] = mk(cts_pkg::KIND_END, 32'd0, cts_pkg::ERR_BADCHAR, line);
                    cnt = cnt + 2'd1;
                    n_halt = 1'b1;
                end else begin
                    n_mode = s_mode;
                    if (s_kind != cts_pkg::KIND_END) begin
                        res[cnt[0]] = mk(s_kind, 32'd0, cts_pkg::ERR_NONE, line);
                        cnt = cnt + 2'd1;
                    end
                    if (s_mode == cts_pkg::M_NUM) n_acc = {28'd0, i_byte[3:0]};
                    if (s_mode == cts_pkg::M_WORD) begin
                        n_word = {56'd0, i_byte};
                        n_len = LW'(1);
                    end
                end
            end
            if (cnt == 2'd1) res[0].last = 1'b1;
            if (cnt == 2'd2) res[1].last = 1'b1;
        end
    end

    assign o_cnt = cnt;
    assign o_res = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= cts_pkg::M_START;
            r_acc  <= '0;
            r_len  <= '0;
            r_line <= 24'd1;
            r_halt <= 1'b0;
        end else begin
            r_mode <= n_mode;
            r_acc  <= n_acc;
            r_len  <= n_len;
            r_line <= n_line;
            r_halt <= n_halt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

endmodule

`default_nettype wire

// File: rtl/cts_outq.sv
// result queue, takes up to two results per cycle and hands out one when taken
// depends on cts_pkg
`default_nettype none

module cts_outq (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [1:0]       i_cnt,
    input  cts_pkg::t_result      i_res [2],
    output logic                  o_room,
    output logic                  o_valid,
    input  wire logic             i_take,
    output cts_pkg::t_result      o_head
);
    localparam int AW = cts_pkg::Q_AW;

    cts_pkg::t_result r_mem [cts_pkg::Q_DEPTH];
    logic [AW-1:0] r_wr, n_wr, r_rd, n_rd;
    logic [AW:0] r_cnt, n_cnt;
    logic pop;

    assign pop     = i_take && (r_cnt != '0);
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd];
    assign o_room  = (r_cnt <= (AW+1)'(cts_pkg::Q_DEPTH - 2));

    always_comb begin
        n_wr  = r_wr + AW'(i_cnt);
        n_rd  = r_rd + AW'(pop);
        n_cnt = r_cnt + (AW+1)'(i_cnt) - (AW+1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_cnt != 2'd0) r_mem[r_wr] <= i_res[0];
        if (i_cnt == 2'd2) r_mem[r_wr + AW'(1)] <= i_res[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

// File: rtl/c_token_scanner.sv
// top level of the c token scanner: scan core and result queue
// depends on cts_pkg, cts_core, cts_outq
//
// channel   dir  tdata                        tuser                  tlast
// s_axis    in   [7:0] byte_value             [0] end_of_input       -
// m_axis    out  [31:0] literal_value,        [6:0] token_kind,      last_of_run
//                [55:32] error_line           [9:7] error_code
//
// one byte per cycle; the scan core updates its state in the cycle of the transaction
// a byte gives up to two results, queued four deep; the output drains one per cycle
// while m_axis_tready is high; s_axis_tready drops while fewer than two slots are free
// reset is synchronous; after an error all input is taken and dropped until reset
`default_nettype none

module c_token_scanner #(
    parameter int MaxWord = cts_pkg::MAX_WORD_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,  // [7:0] byte_value
    input  wire logic        s_axis_tuser,  // [0] end_of_input
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [55:0]      m_axis_tdata,  // [31:0] literal_value, [55:32] error_line
    output logic [9:0]       m_axis_tuser,  // [6:0] token_kind, [9:7] error_code
    output logic             m_axis_tlast   // last_of_run
);
    logic go;
    logic [1:0] cnt;
    cts_pkg::t_result res [2];
    cts_pkg::t_result head;

    assign go = s_axis_tvalid && s_axis_tready;

    cts_core #(.MaxWord(MaxWord)) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (go),
        .i_byte  (s_axis_tdata),
        .i_end   (s_axis_tuser),
        .o_cnt   (cnt),
        .o_res   (res)
    );

    cts_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cnt   (cnt),
        .i_res   (res),
        .o_room  (s_axis_tready),
        .o_valid (m_axis_tvalid),
        .i_take  (m_axis_tready),
        .o_head  (head)
    );

    assign m_axis_tdata = {head.line, head.value};
    assign m_axis_tuser = {head.err, head.kind};
    assign m_axis_tlast = head.last;

endmodule

`default_nettype wire

// File: verif/testbench.sv
// self-checking testbench of the c token scanner: byte stream in, token stream out
// depends on cts_pkg and c_token_scanner in rtl
`timescale 1ns / 100ps

module testbench;

    typedef struct {
        logic [7:0] ch;
        logic       eoi;
    } t_src;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;
    logic [9:0]  m_axis_tuser;
    logic        m_axis_tlast;

    c_token_scanner dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    t_src             src_q[$];
    cts_pkg::t_result token_q[$];
    int      n_fail, n_bytes, n_tokens, n_ends, total_src, cycles;
    int      err_sel;
    bit      in_flight, started;
    int      src_gap, sink_gap;
    logic [7:0] last_ch;

    string kw_names[32] = '{
        "auto", "break", "case", "char", "const", "continue", "default", "do",
        "double", "else", "enum", "extern", "float", "for", "goto", "if",
        "int", "long", "register", "return", "short", "signed", "sizeof", "static",
        "struct", "switch", "typedef", "union", "unsigned", "void", "volatile", "while"
    };
    string punct_txt[46] = '{
        "+=", "++", "+", "-=", "--", "->", "-", "*=", "*", "/=", "/", ">>=", ">>",
        ">=", ">", "<<=", "<<", "<=", "<", "...", ".", "%=", "%", "&=", "&&", "&",
        "^=", "^", "|=", "||", "|", "{", "}", ";", "!=", "!", "~", "==", "=", ",",
        ":", "(", ")", "[", "]", "?"
    };
    string blanks[4] = '{" ", "\t", "\r", "\n"};

    // scanner state of the predictor
    cts_pkg::t_mode mode;
    logic [31:0] acc;
    logic [7:0]  letters[32];
    int          wlen;
    logic [23:0] line_no;
    bit          halted;

    function automatic void emit_token(logic [6:0] kind, logic [31:0] val, logic [2:0] err);
        token_q.push_back('{kind: kind, value: val, err: err, line: line_no, last: 1'b0});
    endfunction

    function automatic void raise_error(logic [2:0] err);
        emit_token(cts_pkg::KIND_END, 0, err);
        halted = 1;
    endfunction

    function automatic void close_word();
        bit same;
        for (int k = 0; k < 32; k++) begin
            same = (kw_names[k].len() == wlen);
            for (int i = 0; same && i < wlen; i++) same = (kw_names[k][i] == letters[i]);
            if (same) begin
                emit_token(cts_pkg::KIND_KW0 + 7'(k), 0, cts_pkg::ERR_NONE);
                return;
            end
        end
        raise_error(cts_pkg::ERR_WORD);
    endfunction

    function automatic void flush_token();
        case (mode)
            cts_pkg::M_NUM:    emit_token(cts_pkg::KIND_INT, acc, cts_pkg::ERR_NONE);
            cts_pkg::M_WORD:   close_word();
            cts_pkg::M_DOTDOT: raise_error(cts_pkg::ERR_DOTS);
            cts_pkg::M_PLUS:   emit_token(7'd3, 0, cts_pkg::ERR_NONE);
            cts_pkg::M_MINUS:  emit_token(7'd7, 0, cts_pkg::ERR_NONE);
            cts_pkg::M_STAR:   emit_token(7'd9, 0, cts_pkg::ERR_NONE);
            cts_pkg::M_SLASH:  emit_token(7'd11, 0, cts_pkg::ERR_NONE);
            cts_pkg::M_GT:     emit_token(7'd15, 0, cts_pkg::ERR_NONE);
            cts_pkg::M_GTGT:   emit_token(7'd13, 0, cts_pkg::ERR_NONE);
            cts_pkg::M_LT:     emit_token(7'd19, 0, cts_pkg::ERR_NONE);
            cts_pkg::M_LTLT:   emit_token(7'd17, 0, cts_pkg::ERR_NONE);
            cts_pkg::M_DOT:    emit_token(7'd21, 0, cts_pkg::ERR_NONE);
            cts_pkg::M_PCT:    emit_token(7'd23, 0, cts_pkg::ERR_NONE);
            cts_pkg::M_AMP:    emit_token(7'd26, 0, cts_pkg::ERR_NONE);
            cts_pkg::M_CARET:  emit_token(7'd28, 0, cts_pkg::ERR_NONE);
            cts_pkg::M_PIPE:   emit_token(7'd31, 0, cts_pkg::ERR_NONE);
            cts_pkg::M_BANG:   emit_token(7'd36, 0, cts_pkg::ERR_NONE);
            cts_pkg::M_EQ:     emit_token(7'd39, 0, cts_pkg::ERR_NONE);
            default: ;
        endcase
        mode = cts_pkg::M_START;
    endfunction

    function automatic bit complete(logic [6:0] kind);
        emit_token(kind, 0, cts_pkg::ERR_NONE);
        mode = cts_pkg::M_START;
        return 1;
    endfunction

    function automatic bit extend_token(logic [7:0] c);
        case (mode)
            cts_pkg::M_PLUS:  begin
                if (c == "=") return complete(7'd1);
                if (c == "+") return complete(7'd2);
            end
            cts_pkg::M_MINUS: begin
                if (c == "=") return complete(7'd4);
                if (c == "-") return complete(7'd5);
                if (c == ">") return complete(7'd6);
            end
            cts_pkg::M_STAR:  if (c == "=") return complete(7'd8);
            cts_pkg::M_SLASH: if (c == "=") return complete(7'd10);
            cts_pkg::M_GT: begin
                if (c == ">") begin
                    mode = cts_pkg::M_GTGT;
                    return 1;
                end
                if (c == "=") return complete(7'd14);
            end
            cts_pkg::M_GTGT:  if (c == "=") return complete(7'd12);
            cts_pkg::M_LT: begin
                if (c == "<") begin
                    mode = cts_pkg::M_LTLT;
                    return 1;
                end
                if (c == "=") return complete(7'd18);
            end
            cts_pkg::M_LTLT:  if (c == "=") return complete(7'd16);
            cts_pkg::M_DOT: begin
                if (c == ".") begin
                    mode = cts_pkg::M_DOTDOT;
                    return 1;
                end
            end
            cts_pkg::M_DOTDOT: if (c == ".") return complete(7'd20);
            cts_pkg::M_PCT:   if (c == "=") return complete(7'd22);
            cts_pkg::M_AMP: begin
                if (c == "=") return complete(7'd24);
                if (c == "&") return complete(7'd25);
            end
            cts_pkg::M_CARET: if (c == "=") return complete(7'd27);
            cts_pkg::M_PIPE: begin
                if (c == "=") return complete(7'd29);
                if (c == "|") return complete(7'd30);
            end
            cts_pkg::M_BANG:  if (c == "=") return complete(7'd35);
            cts_pkg::M_EQ:    if (c == "=") return complete(7'd38);
            cts_pkg::M_NUM: begin
                if (c >= "0" && c <= "9") begin
                    acc = acc * 10 + 32'(c - "0");
                    return 1;
                end
            end
            cts_pkg::M_WORD: begin
                if (c >= "a" && c <= "z") begin
                    if (wlen >= cts_pkg::MAX_WORD_DEF) raise_error(cts_pkg::ERR_LONG);
                    else begin
                        letters[wlen] = c;
                        wlen++;
                    end
                    return 1;
                end
            end
            default: ;
        endcase
        return 0;
    endfunction

    function automatic void begin_token(logic [7:0] c);
        case (c)
            " ", "\t", "\n", "\r": ;
            "+": mode = cts_pkg::M_PLUS;
            "-": mode = cts_pkg::M_MINUS;
            "*": mode = cts_pkg::M_STAR;
            "/": mode = cts_pkg::M_SLASH;
            ">": mode = cts_pkg::M_GT;
            "<": mode = cts_pkg::M_LT;
            ".": mode = cts_pkg::M_DOT;
            "%": mode = cts_pkg::M_PCT;
            "&": mode = cts_pkg::M_AMP;
            "^": mode = cts_pkg::M_CARET;
            "|": mode = cts_pkg::M_PIPE;
            "!": mode = cts_pkg::M_BANG;
            "=": mode = cts_pkg::M_EQ;
            "{": emit_token(7'd32, 0, cts_pkg::ERR_NONE);
            "}": emit_token(7'd33, 0, cts_pkg::ERR_NONE);
            ";": emit_token(7'd34, 0, cts_pkg::ERR_NONE);
            "~": emit_token(7'd37, 0, cts_pkg::ERR_NONE);
            ",": emit_token(7'd40, 0, cts_pkg::ERR_NONE);
            ":": emit_token(7'd41, 0, cts_pkg::ERR_NONE);
            "(": emit_token(7'd42, 0, cts_pkg::ERR_NONE);
            ")": emit_token(7'd43, 0, cts_pkg::ERR_NONE);
            "[": emit_token(7'd44, 0, cts_pkg::ERR_NONE);
            "]": emit_token(7'd45, 0, cts_pkg::ERR_NONE);
            "?": emit_token(7'd46, 0, cts_pkg::ERR_NONE);
            default: begin
                if (c >= "0" && c <= "9") begin
                    mode = cts_pkg::M_NUM;
                    acc = 32'(c - "0");
                end else if (c >= "a" && c <= "z") begin
                    mode = cts_pkg::M_WORD;
                    letters[0] = c;
                    wlen = 1;
                end else begin
                    raise_error(cts_pkg::ERR_BADCHAR);
                end
            end
        endcase
    endfunction

    function automatic void scan_byte(t_src s);
        int before_n;
        before_n = token_q.size();
        if (halted) return;
        if (s.eoi) begin
            flush_token();
            if (!halted) emit_token(cts_pkg::KIND_END, 0, cts_pkg::ERR_NONE);
        end else begin
            if (s.ch == "\n" && line_no < cts_pkg::LINE_MAX) line_no++;
            if (mode == cts_pkg::M_START) begin_token(s.ch);
            else if (!extend_token(s.ch)) begin
                flush_token();
                if (!halted) begin_token(s.ch);
            end
        end
        if (token_q.size() > before_n) token_q[$].last = 1'b1;
    endfunction

    function automatic bit is_letter(logic [7:0] c);
        return c >= "a" && c <= "z";
    endfunction

    function automatic bit is_known(logic [7:0] c);
        return is_letter(c) || (c >= "0" && c <= "9") ||
               c inside {" ", "\t", "\n", "\r", "+", "-", "*", "/", ">", "<", ".", "%",
                         "&", "^", "|", "!", "=", "{", "}", ";", "~", ",", ":", "(", ")",
                         "[", "]", "?"};
    endfunction

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++) begin
            src_q.push_back('{ch: s[i], eoi: 1'b0});
            last_ch = s[i];
        end
    endfunction

    function automatic void push_end();
        src_q.push_back('{ch: 8'($urandom_range(0, 255)), eoi: 1'b1});
        last_ch = " ";
    endfunction

    // appends a fragment, keeping letters and dots of neighbors apart
    function automatic void push_piece(string s);
        if ((is_letter(last_ch) && is_letter(s[0])) || (last_ch == "." && s[0] == "."))
            push_text(blanks[$urandom_range(0, 3)]);
        push_text(s);
        if ($urandom_range(0, 1)) push_text(blanks[$urandom_range(0, 3)]);
    endfunction

    function automatic string digit_run();
        string d;
        int n;
        d = "";
        n = $urandom_range(1, 14);
        for (int i = 0; i < n; i++) d = {d, string'(8'("0" + $urandom_range(0, 9)))};
        return d;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch in %s at token %0d: got %0h, want %0h", what, n_tokens, got, want);
        n_fail++;
    endtask

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // source and sink side: valid is held until the transaction completes
    always @(negedge i_clk) begin
        if (!started) begin
            s_axis_tvalid <= 0;
        end else if (!in_flight) begin
            if (src_gap > 0) begin
                src_gap--;
                s_axis_tvalid <= 0;
            end else if (src_q.size() > 0) begin
                s_axis_tvalid <= 1;
                s_axis_tdata  <= src_q[0].ch;
                s_axis_tuser  <= src_q[0].eoi;
                in_flight = 1;
                if (src_q.size() > 150 && $urandom_range(0, 9) == 0)
                    src_gap = $urandom_range(1, 19);
            end else begin
                s_axis_tvalid <= 0;
            end
        end
        if (sink_gap > 0) begin
            sink_gap--;
            m_axis_tready <= 0;
        end else begin
            m_axis_tready <= 1;
            if (src_q.size() > 150 && $urandom_range(0, 11) == 0)
                sink_gap = $urandom_range(1, 19);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            scan_byte(src_q.pop_front());
            in_flight = 0;
            n_bytes++;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (token_q.size() == 0) begin
                report_mismatch("unexpected token kind", m_axis_tuser[6:0], 0);
            end else begin
                automatic cts_pkg::t_result w = token_q.pop_front();
                if (m_axis_tuser[6:0] !== w.kind) report_mismatch("kind", m_axis_tuser[6:0], w.kind);
                if (m_axis_tdata[31:0] !== w.value)
                    report_mismatch("value", m_axis_tdata[31:0], w.value);
                if (m_axis_tuser[9:7] !== w.err) report_mismatch("error", m_axis_tuser[9:7], w.err);
                if (m_axis_tdata[55:32] !== w.line)
                    report_mismatch("line", m_axis_tdata[55:32], w.line);
                if (m_axis_tlast !== w.last) report_mismatch("last", m_axis_tlast, w.last);
                if (w.kind == cts_pkg::KIND_END && w.err == cts_pkg::ERR_NONE) n_ends++;
            end
            n_tokens++;
        end
        if (cycles > 400000) begin
            $display("timeout after %0d cycles", cycles);
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        logic [7:0] bad;
        s_axis_tvalid = 0;
        s_axis_tdata  = 0;
        s_axis_tuser  = 0;
        m_axis_tready = 0;
        i_rst_n = 0;
        mode = cts_pkg::M_START;
        acc = 0;
        wlen = 0;
        line_no = 1;
        halted = 0;
        last_ch = " ";

        // directed: literal extremes and wrap, keywords, operators, end flush
        push_text("0 4294967295 4294967296\nauto while->..."); push_end();
        push_text("do=if"); push_end();
        while (src_q.size() < 900) begin
            case ($urandom_range(0, 9))
                0, 1:    push_piece(kw_names[$urandom_range(0, 31)]);
                2:       push_piece($urandom_range(0, 1) ? $sformatf("%0d", $urandom) : digit_run());
                3, 4, 5: push_piece(punct_txt[$urandom_range(0, 45)]);
                6:       push_text(blanks[$urandom_range(0, 3)]);
                7:       if ($urandom_range(0, 3) == 0) push_end();
                default: push_piece(punct_txt[$urandom_range(0, 45)]);
            endcase
        end
        if (src_q.size() > 0) push_end();
        for (int i = 0; i < 46; i++) push_piece(punct_txt[i]);
        push_end();

        // one error closes the run, since the scanner stays halted until reset
        err_sel = $urandom_range(1, 4);
        if ($urandom_range(0, 1)) push_piece("+");
        case (err_sel)
            1: begin
                do bad = 8'($urandom_range(0, 255)); while (is_known(bad));
                src_q.push_back('{ch: bad, eoi: 1'b0});
            end
            2: begin
                push_text(" ..");
                if ($urandom_range(0, 1)) push_end(); else push_text("x");
            end
            3: push_text(" qzx ");
            default: begin
                push_text(" ");
                for (int i = 0; i <= cts_pkg::MAX_WORD_DEF; i++) push_text("e");
            end
        endcase
        for (int i = 0; i < 5; i++) push_end();
        total_src = src_q.size();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);
        started = 1;
        while (src_q.size() > 0 || in_flight) @(posedge i_clk);
        while (token_q.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("%0d bytes scanned, %0d tokens checked, %0d end tokens",
                 n_bytes, n_tokens, n_ends);
        $display("run closed by error code %0d on line %0d", err_sel, line_no);
        if (n_fail == 0 && token_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
